// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL of the trial factoring block.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SNF_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SNF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/snf_pkg.sv =====
// Shared types, constants and the control program of the trial factoring block.
// No dependencies; imported by snf_seq and smooth_number_trial_factor.
package snf_pkg;

    localparam int NUM_PRIMES = 13;
    localparam int PIDX_W     = 4;
    localparam int EXP_W      = 6;
    localparam int VAL_W      = 64;
    localparam int HALF_W     = VAL_W / 2;

    localparam logic [VAL_W-1:0] MAX_VAL = '1;

    // Inverse of an odd p modulo 2^64 by Newton steps: 3 -> 6 -> 12 -> 24 -> 48 -> 96 bits.
    function automatic logic [VAL_W-1:0] inv64(input logic [VAL_W-1:0] p);
        logic [VAL_W-1:0] x;
        x = p;
        for (int i = 0; i < 5; i++)
        begin
            x = x * (64'd2 - p * x);
        end
        return x;
    endfunction

    // Entry 0 (the prime 2) is handled by shifting; its inverse is unused.
    localparam logic [VAL_W-1:0] INV_TABLE [NUM_PRIMES] = '{
        64'd1,        inv64(64'd3),  inv64(64'd5),  inv64(64'd7),  inv64(64'd11),
        inv64(64'd13), inv64(64'd17), inv64(64'd19), inv64(64'd23), inv64(64'd29),
        inv64(64'd31), inv64(64'd37), inv64(64'd41)
    };

    // x * inv(p) mod 2^64 is the exact quotient iff it does not exceed this bound.
    localparam logic [VAL_W-1:0] LIMIT_TABLE [NUM_PRIMES] = '{
        MAX_VAL / 64'd2,  MAX_VAL / 64'd3,  MAX_VAL / 64'd5,  MAX_VAL / 64'd7,
        MAX_VAL / 64'd11, MAX_VAL / 64'd13, MAX_VAL / 64'd17, MAX_VAL / 64'd19,
        MAX_VAL / 64'd23, MAX_VAL / 64'd29, MAX_VAL / 64'd31, MAX_VAL / 64'd37,
        MAX_VAL / 64'd41
    };

    typedef enum logic [3:0] {
        STEP_WAIT     = 4'd0,
        STEP_CHECK    = 4'd1,
        STEP_MUL0     = 4'd2,
        STEP_MUL1     = 4'd3,
        STEP_MUL2     = 4'd4,
        STEP_DIV_ODD  = 4'd5,
        STEP_DIV_EVEN = 4'd6,
        STEP_NEXTP    = 4'd7,
        STEP_EMIT     = 4'd8
    } step_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL0,
        OP_MUL1,
        OP_MUL2,
        OP_DIV_ODD,
        OP_DIV_EVEN,
        OP_STORE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN_VALID,
        COND_TRIVIAL,
        COND_IS_TWO,
        COND_DIV_OK,
        COND_EVEN_OK,
        COND_LAST_PRIME,
        COND_EMIT_DONE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t jt;
        step_t jf;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic trivial;
        logic is_two;
        logic div_ok;
        logic even_ok;
        logic last_prime;
        logic emit_done;
    } seq_status_t;

    // Control store: one word per step, branch to jt when cond holds, else jf.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        case (s)
            STEP_WAIT:     w = '{OP_LOAD,     COND_IN_VALID,   STEP_CHECK,  STEP_WAIT};
            STEP_CHECK:    w = '{OP_NONE,     COND_TRIVIAL,    STEP_NEXTP,  STEP_MUL0};
            STEP_MUL0:     w = '{OP_MUL0,     COND_IS_TWO,     STEP_DIV_EVEN, STEP_MUL1};
            STEP_MUL1:     w = '{OP_MUL1,     COND_ALWAYS,     STEP_MUL2,   STEP_MUL2};
            STEP_MUL2:     w = '{OP_MUL2,     COND_ALWAYS,     STEP_DIV_ODD, STEP_DIV_ODD};
            STEP_DIV_ODD:  w = '{OP_DIV_ODD,  COND_DIV_OK,     STEP_CHECK,  STEP_NEXTP};
            STEP_DIV_EVEN: w = '{OP_DIV_EVEN, COND_EVEN_OK,    STEP_CHECK,  STEP_NEXTP};
            STEP_NEXTP:    w = '{OP_STORE,    COND_LAST_PRIME, STEP_EMIT,   STEP_CHECK};
            STEP_EMIT:     w = '{OP_EMIT,     COND_EMIT_DONE,  STEP_WAIT,   STEP_EMIT};
            default:       w = '{OP_NONE,     COND_ALWAYS,     STEP_WAIT,   STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== design/smooth_number_trial_factor.sv =====
// Trial factoring over 2..41: a 64-bit word in, thirteen (index, exponent) words out.
// Flow: a load step, then for each prime one trial per factor found, one failing trial
// (only the check once the cofactor is 0 or 1) and a store step. A trial for 2 is check,
// multiply and shift; one for an odd prime is check, three passes through the single
// 32x32 multiplier and compare. Then one output word per cycle while m_axis_tready is high.
// One word in flight at a time. Reset returns the sequencer to waiting; nothing is cleared.
module smooth_number_trial_factor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] prime_index, [9:4] exponent, [15:10] zero
    output logic        m_axis_tuser,   // [0] smooth
    output logic        m_axis_tlast
);
    import snf_pkg::*;

    op_t         op;
    seq_status_t status;

    logic [VAL_W-1:0]  rest_reg, rest_next;
    logic [VAL_W-1:0]  prod_reg, prod_next;
    logic [EXP_W-1:0]  e_reg, e_next;
    logic [PIDX_W-1:0] k_reg, k_next;
    logic [PIDX_W-1:0] idx_reg, idx_next;
    logic [EXP_W-1:0]  exp_reg [NUM_PRIMES];

    logic [HALF_W-1:0] mul_a, mul_b;
    logic [VAL_W-1:0]  mul_p;
    logic [VAL_W-1:0]  inv_k;
    logic              last_out;

    snf_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    assign inv_k    = INV_TABLE[k_reg];
    assign last_out = (idx_reg == PIDX_W'(NUM_PRIMES - 1));

    // Low 64 bits of rest * inv(p), built from three 32x32 partial products.
    assign mul_a = (op == OP_MUL1) ? rest_reg[VAL_W-1:HALF_W] : rest_reg[HALF_W-1:0];
    assign mul_b = (op == OP_MUL2) ? inv_k[VAL_W-1:HALF_W] : inv_k[HALF_W-1:0];
    assign mul_p = VAL_W'(mul_a) * VAL_W'(mul_b);

    always_comb
    begin
        status.in_valid   = s_axis_tvalid;
        status.trivial    = (rest_reg == '0) || (rest_reg == VAL_W'(1));
        status.is_two     = (k_reg == '0);
        status.div_ok     = (prod_reg <= LIMIT_TABLE[k_reg]);
        status.even_ok    = !rest_reg[0];
        status.last_prime = (k_reg == PIDX_W'(NUM_PRIMES - 1));
        status.emit_done  = m_axis_tready && last_out;
    end

    always_comb
    begin
        rest_next = rest_reg;
        prod_next = prod_reg;
        e_next    = e_reg;
        k_next    = k_reg;
        idx_next  = idx_reg;
        case (op)
            OP_LOAD:
            begin
                rest_next = s_axis_tdata;
                e_next    = '0;
                k_next    = '0;
                idx_next  = '0;
            end
            OP_MUL0:
                prod_next = mul_p;
            OP_MUL1, OP_MUL2:
                prod_next = {prod_reg[VAL_W-1:HALF_W] + mul_p[HALF_W-1:0],
                             prod_reg[HALF_W-1:0]};
            OP_DIV_ODD:
            begin
                if (status.div_ok)
                begin
                    rest_next = prod_reg;
                    e_next    = e_reg + EXP_W'(1);
                end
            end
            OP_DIV_EVEN:
            begin
                if (status.even_ok)
                begin
                    rest_next = {1'b0, rest_reg[VAL_W-1:1]};
                    e_next    = e_reg + EXP_W'(1);
                end
            end
            OP_STORE:
            begin
                e_next = '0;
                k_next = status.last_prime ? '0 : k_reg + PIDX_W'(1);
            end
            OP_EMIT:
            begin
                if (m_axis_tready)
                    idx_next = last_out ? '0 : idx_reg + PIDX_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rest_reg <= rest_next;
        prod_reg <= prod_next;
        e_reg    <= e_next;
        k_reg    <= k_next;
        idx_reg  <= idx_next;
        if (op == OP_STORE)
            exp_reg[k_reg] <= e_reg;
    end

    assign s_axis_tready = (op == OP_LOAD);
    assign m_axis_tvalid = (op == OP_EMIT);
    assign m_axis_tdata  = {6'd0, exp_reg[idx_reg], idx_reg};
    assign m_axis_tuser  = (rest_reg == VAL_W'(1));
    assign m_axis_tlast  = last_out;

`include "assert_macros.svh"

    `SNF_ASSERT(a_one_side, 1'b1, !(s_axis_tready && m_axis_tvalid), "ready while emitting")
    `SNF_ASSERT(a_idx_range, m_axis_tvalid, m_axis_tdata[3:0] <= 4'(NUM_PRIMES - 1), "bad index")
    `SNF_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "took two words")
    `SNF_ASSERT_NEXT(a_rearm, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready,
        "not ready after last")

endmodule

// ===== design/snf_seq.sv =====
// Microcode sequencer: step counter, control store lookup and branch evaluation.
// Depends on snf_pkg for the program, op codes and status struct.
module snf_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  snf_pkg::seq_status_t status,
    output snf_pkg::op_t        op
);
    import snf_pkg::*;

    step_t  pc_reg;
    step_t  pc_next;
    uword_t word;
    logic   taken;

    assign word = ucode(pc_reg);

    always_comb
    begin
        case (word.cond)
            COND_ALWAYS:     taken = 1'b1;
            COND_IN_VALID:   taken = status.in_valid;
            COND_TRIVIAL:    taken = status.trivial;
            COND_IS_TWO:     taken = status.is_two;
            COND_DIV_OK:     taken = status.div_ok;
            COND_EVEN_OK:    taken = status.even_ok;
            COND_LAST_PRIME: taken = status.last_prime;
            COND_EMIT_DONE:  taken = status.emit_done;
            default:         taken = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = taken ? word.jt : word.jf;
    end

    always_comb
    begin
        op = word.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_WAIT;
        else
            pc_reg <= pc_next;
    end

endmodule
